### rtl/core/upq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Urgency priority queue package
// Shared field widths, result codes, entry layout and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package upq_pkg;

    // Field widths
    localparam int ID_W     = 16;
    localparam int URG_W    = 2;
    localparam int TIME_W   = 4;
    localparam int SRV_W    = 3;
    localparam int OCC_W    = 8;
    localparam int STATUS_W = 2;
    localparam int SRV_CNT_W = 4;   // holds a server count up to 15

    // Input command codes
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd3;

    // One stored queue entry
    typedef struct packed {
        logic [TIME_W-1:0] svc_time;
        logic [URG_W-1:0]  urg;
        logic [ID_W-1:0]   id;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic             insert;   // sorted insert, or reject when full
        logic             pop;      // remove head and report it as served
        logic             none;     // report an empty queue
        logic             last;     // final result of this transfer
        logic [SRV_W-1:0] server;   // server number of a served result
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic one_left;
    } t_dp_status;

endpackage

### rtl/core/urgency_priority_queue_server.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Urgency priority queue server
// Bounded queue sorted by urgency (lower first, equal urgency first-in
// first-out), with arrive and tick commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. An arrive gives one
// result in the cycle after the transfer (accepted, or rejected when full) and
// never raises busy, so arrives can follow back to back. A tick removes one
// entry from the head of the cell row per cycle: it gives min(occupancy,
// servers) results on consecutive cycles, or one none-waiting result on an
// empty queue, and busy stays high until the cycle that shows the last one.
// Every result is valid for one cycle on strobe and cannot be held off.
// Configuration must be written only while idle; the block does not check it.
// The row needs no clearing after reset; the fill count alone marks used cells.
// ----------------------------------------------------------------------------
module urgency_priority_queue_server #(
    parameter int QUEUE_DEPTH = 128,
    parameter int MAX_SERVERS = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_command,
    input  logic [upq_pkg::ID_W-1:0]        i_patient_id,
    input  logic [upq_pkg::URG_W-1:0]       i_urgency,
    input  logic [upq_pkg::TIME_W-1:0]      i_service_time,
    input  logic                            i_cfg_we,
    input  logic [upq_pkg::SRV_W-1:0]       i_cfg_wdata,
    output logic                            strobe,
    output logic [upq_pkg::STATUS_W-1:0]    o_status,
    output logic [upq_pkg::ID_W-1:0]        o_served_id,
    output logic [upq_pkg::URG_W-1:0]       o_served_urgency,
    output logic [upq_pkg::TIME_W-1:0]      o_served_time,
    output logic [upq_pkg::SRV_W-1:0]       o_server_number,
    output logic                            o_last,
    output logic [upq_pkg::OCC_W-1:0]       o_occupancy
);

    upq_pkg::t_dp_cmd    dp_cmd;
    upq_pkg::t_dp_status dp_status;
    logic                ctrl_busy;

    // Controller
    upq_ctrl #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_command   (i_command),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .o_busy      (ctrl_busy)
    );

    // Datapath
    upq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_patient_id     (i_patient_id),
        .i_urgency        (i_urgency),
        .i_service_time   (i_service_time),
        .o_status         (dp_status),
        .o_strobe         (strobe),
        .o_result         (o_status),
        .o_served_id      (o_served_id),
        .o_served_urgency (o_served_urgency),
        .o_served_time    (o_served_time),
        .o_server_number  (o_server_number),
        .o_last           (o_last),
        .o_occupancy      (o_occupancy)
    );

    assign busy = ctrl_busy;

endmodule

### rtl/core/upq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Urgency priority queue controller
// Holds the server count register and sequences a tick into one head
// removal per cycle; arrive commands pass straight to the datapath.
// ----------------------------------------------------------------------------
module upq_ctrl #(
    parameter int MAX_SERVERS = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_command,
    input  logic                         i_cfg_we,
    input  logic [upq_pkg::SRV_W-1:0]    i_cfg_wdata,
    input  upq_pkg::t_dp_status          i_status,
    output upq_pkg::t_dp_cmd             o_cmd,
    output logic                         o_busy
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_SERVE = 1'b1;

    localparam logic [upq_pkg::SRV_CNT_W-1:0] MAX_SRV =
        upq_pkg::SRV_CNT_W'(MAX_SERVERS);
    localparam logic [upq_pkg::SRV_CNT_W-1:0] ONE = upq_pkg::SRV_CNT_W'(1);

    logic                              r_state, n_state;
    logic [upq_pkg::SRV_CNT_W-1:0]     r_servers;
    logic [upq_pkg::SRV_CNT_W-1:0]     r_k, n_k;
    logic [upq_pkg::SRV_CNT_W-1:0]     limit;
    logic                              at_limit_first;
    logic                              at_limit_k;

    // Server count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servers <= MAX_SRV;
        end else if (i_cfg_we) begin
            r_servers <= {1'b0, i_cfg_wdata};
        end
    end

    // Clamp the register to 1..MAX_SERVERS
    always_comb begin
        if (r_servers == '0) begin
            limit = ONE;
        end else if (r_servers > MAX_SRV) begin
            limit = MAX_SRV;
        end else begin
            limit = r_servers;
        end
    end

    assign at_limit_first = (limit == ONE);
    assign at_limit_k     = (r_k == limit);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_command == upq_pkg::CMD_ARRIVE) begin
                        o_cmd.insert = 1'b1;
                        o_cmd.last   = 1'b1;
                    end else if (i_status.empty) begin
                        o_cmd.none = 1'b1;
                        o_cmd.last = 1'b1;
                    end else begin
                        o_cmd.pop    = 1'b1;
                        o_cmd.server = upq_pkg::SRV_W'(1);
                        o_cmd.last   = at_limit_first || i_status.one_left;
                        if (!o_cmd.last) begin
                            n_state = S_SERVE;
                            n_k     = upq_pkg::SRV_CNT_W'(2);
                        end
                    end
                end
            end
            S_SERVE: begin
                o_cmd.pop    = 1'b1;
                o_cmd.server = r_k[upq_pkg::SRV_W-1:0];
                o_cmd.last   = at_limit_k || i_status.one_left;
                if (o_cmd.last) begin
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + ONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    assign o_busy = (r_state == S_SERVE);

endmodule

### rtl/core/upq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Urgency priority queue datapath
// A row of entry cells kept sorted by urgency, with a fill count. Each cell
// compares its own urgency with an arriving one to shift up for an insert;
// a pop shifts the whole row down one place. Results are registered.
// ----------------------------------------------------------------------------
module upq_dpath #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  upq_pkg::t_dp_cmd                i_cmd,
    input  logic [upq_pkg::ID_W-1:0]        i_patient_id,
    input  logic [upq_pkg::URG_W-1:0]       i_urgency,
    input  logic [upq_pkg::TIME_W-1:0]      i_service_time,
    output upq_pkg::t_dp_status             o_status,
    output logic                            o_strobe,
    output logic [upq_pkg::STATUS_W-1:0]    o_result,
    output logic [upq_pkg::ID_W-1:0]        o_served_id,
    output logic [upq_pkg::URG_W-1:0]       o_served_urgency,
    output logic [upq_pkg::TIME_W-1:0]      o_served_time,
    output logic [upq_pkg::SRV_W-1:0]       o_server_number,
    output logic                            o_last,
    output logic [upq_pkg::OCC_W-1:0]       o_occupancy
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);

    upq_pkg::t_entry r_cell [QUEUE_DEPTH];
    upq_pkg::t_entry n_cell [QUEUE_DEPTH];
    upq_pkg::t_entry new_entry;
    logic [QUEUE_DEPTH-1:0] gt;
    logic [CW-1:0]          r_count, n_count;
    logic                   full;
    logic                   ins_ok;
    logic [CW-1:0]          occ_after;
    logic [CW+upq_pkg::OCC_W-1:0] occ_ext;

    logic                            r_strobe;
    logic [upq_pkg::STATUS_W-1:0]    r_result;
    upq_pkg::t_entry                 r_entry;
    logic [upq_pkg::SRV_W-1:0]       r_server;
    logic                            r_last;
    logic [upq_pkg::OCC_W-1:0]       r_occ;

    assign new_entry = '{svc_time: i_service_time, urg: i_urgency, id: i_patient_id};
    assign full      = (r_count == FULL_CNT);
    assign ins_ok    = i_cmd.insert && !full;

    assign o_status.empty    = (r_count == '0);
    assign o_status.one_left = (r_count == ONE_CNT);

    // Per-cell next value
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        assign gt[gi] = (CW'(gi) < r_count) && (r_cell[gi].urg > i_urgency);

        if (gi == 0) begin : g_head
            always_comb begin
                n_cell[gi] = r_cell[gi];
                if (ins_ok) begin
                    if (gt[gi] || (r_count == '0)) begin
                        n_cell[gi] = new_entry;
                    end
                end else if (i_cmd.pop) begin
                    if (QUEUE_DEPTH > 1) begin
                        n_cell[gi] = r_cell[(gi + 1) % QUEUE_DEPTH];
                    end
                end
            end
        end else begin : g_body
            always_comb begin
                n_cell[gi] = r_cell[gi];
                if (ins_ok) begin
                    if (gt[gi-1]) begin
                        n_cell[gi] = r_cell[gi-1];
                    end else if (gt[gi] || (r_count == CW'(gi))) begin
                        n_cell[gi] = new_entry;
                    end
                end else if (i_cmd.pop && (gi < QUEUE_DEPTH - 1)) begin
                    n_cell[gi] = r_cell[(gi + 1) % QUEUE_DEPTH];
                end
            end
        end
    end

    // Cell row, contents need no reset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    // Fill count
    always_comb begin
        n_count = r_count;
        if (ins_ok) begin
            n_count = r_count + ONE_CNT;
        end else if (i_cmd.pop) begin
            n_count = r_count - ONE_CNT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Occupancy reported after the transfer, truncated to the port width
    assign occ_after = i_cmd.none ? '0 : n_count;
    assign occ_ext   = {{upq_pkg::OCC_W{1'b0}}, occ_after};

    // Result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.insert || i_cmd.pop || i_cmd.none;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last   <= i_cmd.last;
        r_server <= i_cmd.server;
        r_occ    <= occ_ext[upq_pkg::OCC_W-1:0];
        if (i_cmd.insert) begin
            r_result <= full ? upq_pkg::ST_REJECTED : upq_pkg::ST_ACCEPTED;
            r_entry  <= new_entry;
        end else if (i_cmd.pop) begin
            r_result <= upq_pkg::ST_SERVED;
            r_entry  <= r_cell[0];
        end else begin
            r_result <= upq_pkg::ST_NONE;
            r_entry  <= '0;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_result         = r_result;
    assign o_served_id      = r_entry.id;
    assign o_served_urgency = r_entry.urg;
    assign o_served_time    = r_entry.svc_time;
    assign o_server_number  = r_server;
    assign o_last           = r_last;
    assign o_occupancy      = r_occ;

endmodule

### rtl/core/upq_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Urgency priority queue port checker
// Watches the top-level ports for result sequencing rules.
// ----------------------------------------------------------------------------
module upq_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            i_command,
    input logic                            strobe,
    input logic [upq_pkg::STATUS_W-1:0]    o_status,
    input logic                            o_last,
    input logic [upq_pkg::OCC_W-1:0]       o_occupancy
);

    // While serving, a result shows on every cycle
    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> strobe)
        else $error("busy without a result");

    // An arrive transfer gives a single accepted or rejected result
    a_arrive_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == upq_pkg::CMD_ARRIVE)) |=>
        (strobe && o_last &&
         ((o_status == upq_pkg::ST_ACCEPTED) || (o_status == upq_pkg::ST_REJECTED))))
        else $error("arrive result missing or malformed");

    // More results pending keeps busy up; the last one drops it
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && !o_last) |-> busy)
        else $error("non-final result while idle");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && o_last) |-> !busy)
        else $error("busy after final result");

    // Consecutive served results drain the queue one entry at a time
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && !o_last && (o_status == upq_pkg::ST_SERVED)) |=>
        (o_occupancy == upq_pkg::OCC_W'($past(o_occupancy) - 8'd1)))
        else $error("occupancy did not step down");

endmodule

bind urgency_priority_queue_server upq_chk u_upq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_command   (i_command),
    .strobe      (strobe),
    .o_status    (o_status),
    .o_last      (o_last),
    .o_occupancy (o_occupancy)
);
